[sv/dst_pkg.sv]
package dst_pkg;

  // Field widths fixed by the interface
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DNUM_W   = 18;
  localparam int COUNT_W  = 16;
  localparam int OUTC_W   = 2;
  localparam int YOFF_W   = 9;

  // Calendar constants
  localparam logic [YEAR_W-1:0] YEAR_BASE = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_LAST = 12'd2399;

  typedef logic [DNUM_W-1:0] dnum_t;
  typedef logic [OUTC_W-1:0] outcome_t;

  // Outcome codes carried with each result word
  localparam outcome_t OUTC_FIRST   = 2'd0;
  localparam outcome_t OUTC_EXTEND  = 2'd1;
  localparam outcome_t OUTC_RESTART = 2'd2;
  localparam outcome_t OUTC_KEEP    = 2'd3;

  // Days in the months before the given month of a common year. Month 0
  // reads as January and months 13 to 15 read as December.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

[sv/dst_day_number.sv]
module dst_day_number (
  input  logic [dst_pkg::YEAR_W-1:0]  year,
  input  logic [dst_pkg::MONTH_W-1:0] month,
  input  logic [dst_pkg::DAY_W-1:0]   day_of_month,
  output dst_pkg::dnum_t              day_number
);

  logic [dst_pkg::YEAR_W-1:0] year_c;
  logic [dst_pkg::YOFF_W-1:0] n;
  logic [dst_pkg::YOFF_W:0]   n_p3;
  logic [2:0]                 centuries;
  logic                       leap;
  logic                       past_feb;
  dst_pkg::dnum_t             sum;

  // Clamp the year into the supported four centuries.
  always_comb begin
    if (year < dst_pkg::YEAR_BASE) begin
      year_c = dst_pkg::YEAR_BASE;
    end else if (year > dst_pkg::YEAR_LAST) begin
      year_c = dst_pkg::YEAR_LAST;
    end else begin
      year_c = year;
    end
  end

  assign n    = dst_pkg::YOFF_W'(year_c - dst_pkg::YEAR_BASE);
  assign n_p3 = {1'b0, n} + 10'd3;

  // Century years passed since the base year (excluded from the leap count);
  // the base year itself is the one fourth-century year in range.
  assign centuries = 3'(n > 9'd0) + 3'(n > 9'd100) + 3'(n > 9'd200) + 3'(n > 9'd300);

  // Leap rule within the range: every fourth year except the three centuries.
  assign leap     = (n[1:0] == 2'b00) && (n != 9'd100) && (n != 9'd200) && (n != 9'd300);
  assign past_feb = (month > 4'd2);

  // Closed form for the days before the year, then month and day.
  always_comb begin
    sum = dst_pkg::DNUM_W'(n) * 18'd365;
    sum = sum + dst_pkg::DNUM_W'(n_p3[dst_pkg::YOFF_W:2]);
    sum = sum - dst_pkg::DNUM_W'(centuries);
    sum = sum + dst_pkg::DNUM_W'(n != 9'd0);
    sum = sum + dst_pkg::DNUM_W'(dst_pkg::days_before_month(month));
    sum = sum + dst_pkg::DNUM_W'(leap && past_feb);
    sum = sum + dst_pkg::DNUM_W'(day_of_month);
  end

  assign day_number = sum;

endmodule

[sv/daily_streak_tracker.sv]
// Channel  Direction  Ports                                       Word
// in       input      in_valid, in_ready                          year, month, day_of_month
// out      output     out_valid, out_ready                        streak_count, day_number,
//                                                                 outcome
//
// Each word passes from input to result through the input register, then through
// the day-number and streak logic into the result register.
// One word is taken per cycle while results are drained; the streak state is
// updated as a word moves into the result register, so each word sees the last.
// Reset (synchronous, active low) empties both registers and clears the history.
// A stalled result holds the result register; one further word waits in the
// input register, after which in_ready falls.
module daily_streak_tracker #(
  parameter int STREAK_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dst_pkg::YEAR_W-1:0]          in_year,
  input  logic [dst_pkg::MONTH_W-1:0]         in_month,
  input  logic [dst_pkg::DAY_W-1:0]           in_day_of_month,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dst_pkg::COUNT_W-1:0]         out_streak_count,
  output logic [dst_pkg::DNUM_W-1:0]          out_day_number,
  output logic [dst_pkg::OUTC_W-1:0]          out_outcome
);

  localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;
  localparam logic [STREAK_BITS-1:0] STREAK_ONE = STREAK_BITS'(1);

  logic                         s1_valid_r, s1_valid_nxt;
  logic [dst_pkg::YEAR_W-1:0]   s1_year_r;
  logic [dst_pkg::MONTH_W-1:0]  s1_month_r;
  logic [dst_pkg::DAY_W-1:0]    s1_day_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [dst_pkg::COUNT_W-1:0]  out_count_r;
  dst_pkg::dnum_t               out_dnum_r;
  dst_pkg::outcome_t            out_outc_r;
  logic                         have_last_r, have_last_nxt;
  dst_pkg::dnum_t               last_day_r, last_day_nxt;
  logic [STREAK_BITS-1:0]       streak_r, streak_nxt;

  dst_pkg::dnum_t               today;
  logic [dst_pkg::DNUM_W:0]     last_p1;
  logic [dst_pkg::DNUM_W:0]     today_x;
  dst_pkg::outcome_t            outc;
  logic [31:0]                  streak_wide;
  logic                         in_fire;
  logic                         s1_fire;
  logic                         out_fire;

  // Handshake: the result register frees itself when taken, the input
  // register frees itself when its word moves on.
  assign out_fire = out_valid_r && out_ready;
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_fire);

  // Day number of the word in the input register.
  dst_day_number u_day_number (
    .year         (s1_year_r),
    .month        (s1_month_r),
    .day_of_month (s1_day_r),
    .day_number   (today)
  );

  assign last_p1 = {1'b0, last_day_r} + 19'd1;
  assign today_x = {1'b0, today};

  // Streak update against the stored history.
  always_comb begin
    have_last_nxt = have_last_r;
    last_day_nxt  = last_day_r;
    streak_nxt    = streak_r;
    if (!have_last_r) begin
      outc = dst_pkg::OUTC_FIRST;
    end else if (today_x == last_p1) begin
      outc = dst_pkg::OUTC_EXTEND;
    end else if (today_x > last_p1) begin
      outc = dst_pkg::OUTC_RESTART;
    end else begin
      outc = dst_pkg::OUTC_KEEP;
    end
    if (s1_fire) begin
      case (outc)
        dst_pkg::OUTC_FIRST, dst_pkg::OUTC_RESTART: begin
          have_last_nxt = 1'b1;
          last_day_nxt  = today;
          streak_nxt    = STREAK_ONE;
        end
        dst_pkg::OUTC_EXTEND: begin
          last_day_nxt = today;
          if (streak_r != STREAK_MAX) begin
            streak_nxt = streak_r + STREAK_ONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign streak_wide = 32'(streak_nxt);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      have_last_r <= 1'b0;
      last_day_r  <= '0;
      streak_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      have_last_r <= have_last_nxt;
      last_day_r  <= last_day_nxt;
      streak_r    <= streak_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_year_r  <= in_year;
      s1_month_r <= in_month;
      s1_day_r   <= in_day_of_month;
    end
    if (s1_fire) begin
      out_count_r <= streak_wide[dst_pkg::COUNT_W-1:0];
      out_dnum_r  <= today;
      out_outc_r  <= outc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_streak_count = out_count_r;
  assign out_day_number   = out_dnum_r;
  assign out_outcome      = out_outc_r;

  // A word leaving the input register always lands in the result register.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid)
    else $error("word lost between input and result registers");

  // Once a history exists the streak is never zero.
  a_streak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    have_last_r |-> (streak_r != '0))
    else $error("streak zero with history present");

  // Without history the first word must report the first-date outcome.
  a_first_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !have_last_r) |=> (out_outcome == dst_pkg::OUTC_FIRST) && have_last_r)
    else $error("first word not reported as first date");

  // An unchanged outcome leaves the stored history alone.
  a_keep_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (outc == dst_pkg::OUTC_KEEP)) |=> $stable(last_day_r) && $stable(streak_r))
    else $error("history changed on an unchanged outcome");

  // Backpressure only arises from a held word in the input register.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without cause");

endmodule
